>>> hdl/ihds_pkg.sv
// shared types, constants and header tables for the image header dimension sniffer
package ihds_pkg;

    localparam int unsigned MAX_STREAM_BYTES = 16777216;
    localparam int unsigned POS_W = $clog2(MAX_STREAM_BYTES + 2);

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_LIMIT = pos_t'(MAX_STREAM_BYTES);
    localparam pos_t POS_OVER  = pos_t'(MAX_STREAM_BYTES + 1);

    typedef enum logic [1:0] {
        FMT_PNG     = 2'd0,
        FMT_JPEG    = 2'd1,
        FMT_WEBP    = 2'd2,
        FMT_UNKNOWN = 2'd3
    } format_t;

    typedef enum logic [1:0] {
        OUT_FOUND    = 2'd0,
        OUT_BAD      = 2'd1,
        OUT_TOO_LONG = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        PH_SOI   = 3'd0,
        PH_FF    = 3'd1,
        PH_MARK  = 3'd2,
        PH_LENHI = 3'd3,
        PH_LENLO = 3'd4,
        PH_SKIP  = 3'd5,
        PH_SOF   = 3'd6,
        PH_DONE  = 3'd7
    } phase_t;

    localparam logic [7:0] JPEG_FILL = 8'hFF;
    localparam logic [7:0] JPEG_SOI  = 8'hD8;
    localparam logic [7:0] JPEG_SOS  = 8'hDA;
    localparam logic [7:0] JPEG_EOI  = 8'hD9;
    localparam logic [7:0] JPEG_SOF0 = 8'hC0;
    localparam logic [7:0] JPEG_SOF2 = 8'hC2;

    localparam logic [7:0] WEBP_VP8X = 8'h58;
    localparam logic [7:0] WEBP_VP8  = 8'h20;
    localparam logic [7:0] WEBP_VP8L = 8'h4C;
    localparam logic [7:0] VP8L_SIG  = 8'd47;

    localparam logic [7:0] PNG_HEAD [16] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52
    };

    // entries 4 to 7 are the riff size and are not checked
    localparam logic [7:0] WEBP_HEAD [16] = '{
        8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h57, 8'h45, 8'h42, 8'h50, 8'h56, 8'h50, 8'h38, 8'h00
    };

    typedef struct packed {
        logic [31:0] image_width;
        logic [31:0] image_height;
        outcome_t    outcome;
    } result_t;

endpackage

>>> hdl/ihds_parse.sv
// header parser state and per-byte next-state logic for png, jpeg and webp
module ihds_parse
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              file_restart,
    input  logic              step,
    input  ihds_pkg::format_t mode,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output ihds_pkg::result_t result
);

    ihds_pkg::pos_t   pos_reg, pos_next;
    ihds_pkg::phase_t phase_reg, phase_next;
    logic             match_reg, match_next;
    logic [7:0]       marker_reg, marker_next;
    logic [15:0]      skip_reg, skip_next;
    ihds_pkg::pos_t   req_reg, req_next;
    logic [31:0]      width_reg, width_next;
    logic [31:0]      height_reg, height_next;
    logic [7:0]       held_reg, held_next;
    logic             verdict_reg, verdict_next;

    ihds_pkg::pos_t   p;
    logic [7:0]       b;
    logic [15:0]      seg_len;

    assign p = pos_reg;
    assign b = data_byte;
    assign seg_len = {held_reg, b};

    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        match_next   = match_reg;
        marker_next  = marker_reg;
        skip_next    = skip_reg;
        req_next     = req_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        held_next    = held_reg;
        verdict_next = verdict_reg;

        if (p >= ihds_pkg::POS_LIMIT)
        begin
            pos_next = ihds_pkg::POS_OVER;
        end
        else
        begin
            pos_next = p + ihds_pkg::pos_t'(1);
            if (match_reg && !verdict_reg)
            begin
                unique case (mode)
                    ihds_pkg::FMT_PNG:
                    begin
                        if (p < ihds_pkg::pos_t'(16))
                        begin
                            if (b != ihds_pkg::PNG_HEAD[p[3:0]])
                                match_next = 1'b0;
                        end
                        else if (p < ihds_pkg::pos_t'(20))
                        begin
                            width_next = {width_reg[23:0], b};
                        end
                        else if (p < ihds_pkg::pos_t'(24))
                        begin
                            height_next = {height_reg[23:0], b};
                            if (p == ihds_pkg::pos_t'(23))
                            begin
                                verdict_next = 1'b1;
                                req_next     = ihds_pkg::pos_t'(24);
                            end
                        end
                    end
                    ihds_pkg::FMT_WEBP:
                    begin
                        if (p < ihds_pkg::pos_t'(15))
                        begin
                            if ((p < ihds_pkg::pos_t'(4) || p >= ihds_pkg::pos_t'(8)) &&
                                b != ihds_pkg::WEBP_HEAD[p[3:0]])
                                match_next = 1'b0;
                        end
                        else if (p == ihds_pkg::pos_t'(15))
                        begin
                            if (b == ihds_pkg::WEBP_VP8X || b == ihds_pkg::WEBP_VP8 ||
                                b == ihds_pkg::WEBP_VP8L)
                                marker_next = b;
                            else
                                match_next = 1'b0;
                        end
                        else if (p < ihds_pkg::pos_t'(30))
                        begin
                            if (marker_reg == ihds_pkg::WEBP_VP8X)
                            begin
                                // animation flag
                                if (p == ihds_pkg::pos_t'(20) && b[1])
                                    match_next = 1'b0;
                                else if (p == ihds_pkg::pos_t'(24))
                                    width_next = width_reg | {24'd0, b};
                                else if (p == ihds_pkg::pos_t'(25))
                                    width_next = width_reg | {16'd0, b, 8'd0};
                                else if (p == ihds_pkg::pos_t'(26))
                                    width_next = width_reg | {8'd0, b, 16'd0};
                                else if (p == ihds_pkg::pos_t'(27))
                                    height_next = height_reg | {24'd0, b};
                                else if (p == ihds_pkg::pos_t'(28))
                                    height_next = height_reg | {16'd0, b, 8'd0};
                                else if (p == ihds_pkg::pos_t'(29))
                                begin
                                    width_next   = width_reg + 32'd1;
                                    height_next  = (height_reg | {8'd0, b, 16'd0}) + 32'd1;
                                    verdict_next = 1'b1;
                                    req_next     = ihds_pkg::pos_t'(30);
                                end
                            end
                            else if (marker_reg == ihds_pkg::WEBP_VP8)
                            begin
                                if (p == ihds_pkg::pos_t'(23) && b != 8'h9D)
                                    match_next = 1'b0;
                                else if (p == ihds_pkg::pos_t'(24) && b != 8'h01)
                                    match_next = 1'b0;
                                else if (p == ihds_pkg::pos_t'(25) && b != 8'h2A)
                                    match_next = 1'b0;
                                else if (p == ihds_pkg::pos_t'(26))
                                    width_next = {24'd0, b};
                                else if (p == ihds_pkg::pos_t'(27))
                                    width_next = {18'd0, b[5:0], width_reg[7:0]};
                                else if (p == ihds_pkg::pos_t'(28))
                                    height_next = {24'd0, b};
                                else if (p == ihds_pkg::pos_t'(29))
                                begin
                                    height_next  = {18'd0, b[5:0], height_reg[7:0]};
                                    verdict_next = 1'b1;
                                    req_next     = ihds_pkg::pos_t'(30);
                                end
                            end
                            else
                            begin
                                if (p == ihds_pkg::pos_t'(20) && b != ihds_pkg::VP8L_SIG)
                                    match_next = 1'b0;
                                else if (p == ihds_pkg::pos_t'(21))
                                    width_next = {24'd0, b};
                                else if (p == ihds_pkg::pos_t'(22))
                                begin
                                    width_next  = (width_reg | {18'd0, b[5:0], 8'd0}) + 32'd1;
                                    height_next = {30'd0, b[7:6]};
                                end
                                else if (p == ihds_pkg::pos_t'(23))
                                    height_next = height_reg | {22'd0, b, 2'd0};
                                else if (p == ihds_pkg::pos_t'(24))
                                begin
                                    height_next  = (height_reg | {18'd0, b[3:0], 10'd0}) + 32'd1;
                                    verdict_next = 1'b1;
                                    req_next     = ihds_pkg::pos_t'(30);
                                end
                            end
                        end
                    end
                    ihds_pkg::FMT_JPEG:
                    begin
                        unique case (phase_reg)
                            ihds_pkg::PH_SOI:
                            begin
                                if (p == ihds_pkg::pos_t'(0))
                                begin
                                    if (b != ihds_pkg::JPEG_FILL)
                                        match_next = 1'b0;
                                end
                                else
                                begin
                                    if (b != ihds_pkg::JPEG_SOI)
                                        match_next = 1'b0;
                                    phase_next = ihds_pkg::PH_FF;
                                end
                            end
                            ihds_pkg::PH_FF:
                            begin
                                if (b != ihds_pkg::JPEG_FILL)
                                    match_next = 1'b0;
                                else
                                    phase_next = ihds_pkg::PH_MARK;
                            end
                            ihds_pkg::PH_MARK:
                            begin
                                if (b == ihds_pkg::JPEG_FILL)
                                    phase_next = ihds_pkg::PH_MARK;
                                else if (b == ihds_pkg::JPEG_SOS || b == ihds_pkg::JPEG_EOI)
                                    match_next = 1'b0;
                                else
                                begin
                                    marker_next = b;
                                    phase_next  = ihds_pkg::PH_LENHI;
                                end
                            end
                            ihds_pkg::PH_LENHI:
                            begin
                                held_next  = b;
                                phase_next = ihds_pkg::PH_LENLO;
                            end
                            ihds_pkg::PH_LENLO:
                            begin
                                if (seg_len < 16'd2)
                                    match_next = 1'b0;
                                else if (marker_reg >= ihds_pkg::JPEG_SOF0 &&
                                         marker_reg <= ihds_pkg::JPEG_SOF2)
                                begin
                                    if (seg_len < 16'd8)
                                        match_next = 1'b0;
                                    else
                                    begin
                                        req_next   = (p - ihds_pkg::pos_t'(1)) +
                                                     ihds_pkg::pos_t'(seg_len);
                                        skip_next  = 16'd2;
                                        phase_next = ihds_pkg::PH_SOF;
                                    end
                                end
                                else if (seg_len == 16'd2)
                                    phase_next = ihds_pkg::PH_FF;
                                else
                                begin
                                    skip_next  = seg_len - 16'd2;
                                    phase_next = ihds_pkg::PH_SKIP;
                                end
                            end
                            ihds_pkg::PH_SKIP:
                            begin
                                skip_next = skip_reg - 16'd1;
                                if (skip_reg == 16'd1)
                                    phase_next = ihds_pkg::PH_FF;
                            end
                            ihds_pkg::PH_SOF:
                            begin
                                if (skip_reg == 16'd3)
                                    height_next = {16'd0, b, 8'd0};
                                else if (skip_reg == 16'd4)
                                    height_next = height_reg | {24'd0, b};
                                else if (skip_reg == 16'd5)
                                    width_next = {16'd0, b, 8'd0};
                                else if (skip_reg == 16'd6)
                                begin
                                    width_next   = width_reg | {24'd0, b};
                                    verdict_next = 1'b1;
                                    phase_next   = ihds_pkg::PH_DONE;
                                end
                                skip_next = skip_reg + 16'd1;
                            end
                            ihds_pkg::PH_DONE:
                            begin
                                phase_next = ihds_pkg::PH_DONE;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    ihds_pkg::FMT_UNKNOWN:
                    begin
                        match_next = 1'b0;
                    end
                    default:
                    begin
                        match_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.image_width  = 32'd0;
        result.image_height = 32'd0;
        if (pos_next > ihds_pkg::POS_LIMIT)
            result.outcome = ihds_pkg::OUT_TOO_LONG;
        else if (match_next && verdict_next && pos_next >= req_next)
        begin
            result.image_width  = width_next;
            result.image_height = height_next;
            result.outcome      = ihds_pkg::OUT_FOUND;
        end
        else
            result.outcome = ihds_pkg::OUT_BAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= ihds_pkg::PH_SOI;
            match_reg   <= 1'b1;
            marker_reg  <= '0;
            skip_reg    <= '0;
            req_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            held_reg    <= '0;
            verdict_reg <= 1'b0;
        end
        else if (file_restart || (step && last_byte))
        begin
            pos_reg     <= '0;
            phase_reg   <= ihds_pkg::PH_SOI;
            match_reg   <= 1'b1;
            marker_reg  <= '0;
            skip_reg    <= '0;
            req_reg     <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            held_reg    <= '0;
            verdict_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            match_reg   <= match_next;
            marker_reg  <= marker_next;
            skip_reg    <= skip_next;
            req_reg     <= req_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            held_reg    <= held_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

>>> hdl/image_header_dimension_sniffer_core.sv
// top level of the image header dimension sniffer: byte register, parser, result register
//
// usage: bytes of one image file arrive on the data channel (data_byte, last_byte,
// data_valid, data_stall), one beat per byte in file order, last_byte on the final beat.
// format_mode is set through the cfg channel (cfg_valid, cfg_ready, cfg_data) between
// files; a write abandons any file in progress.
// one byte is taken every cycle while data_stall is low; the parser logic
// sits between the byte register and the result register.
// exactly one result beat (image_width, image_height, outcome) follows each last_byte
// beat; result_valid rises once the parser steps past that byte.
// while result_stall holds a result, bytes keep flowing until a further last_byte
// reaches the byte register; data_stall is then raised until the result is taken.
// reset clears the parser to the start of a file, selects png and empties both registers.
module image_header_dimension_sniffer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] image_width,
    output logic [31:0] image_height,
    output logic [1:0]  outcome
);

    ihds_pkg::format_t mode_reg;
    logic              s1_valid_reg;
    logic [7:0]        s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_blocked;
    logic              s1_step;
    logic              data_take;
    logic              cfg_take;
    logic              res_valid_reg;
    ihds_pkg::result_t res_reg;
    ihds_pkg::result_t res_next;

    assign cfg_ready  = !s1_valid_reg;
    assign cfg_take   = cfg_valid && cfg_ready;
    assign s1_blocked = s1_last_reg && res_valid_reg && result_stall;
    assign s1_step    = s1_valid_reg && !s1_blocked;
    assign data_stall = s1_valid_reg && s1_blocked;
    assign data_take  = data_valid && !data_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= ihds_pkg::FMT_PNG;
        else if (cfg_take)
            mode_reg <= ihds_pkg::format_t'(cfg_data);
    end

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (data_take)
            s1_valid_reg <= 1'b1;
        else if (s1_step)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (data_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    ihds_parse u_parse
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_restart (cfg_take),
        .step         (s1_step),
        .mode         (mode_reg),
        .data_byte    (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .result       (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_step && s1_last_reg)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_step && s1_last_reg)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign image_width  = res_reg.image_width;
    assign image_height = res_reg.image_height;
    assign outcome      = res_reg.outcome;

`ifndef SYNTHESIS
    a_zero_dims_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && outcome != ihds_pkg::OUT_FOUND |-> image_width == 32'd0 &&
        image_height == 32'd0)
        else $error("dimensions not zero on a failed result");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> s1_valid_reg && s1_last_reg && result_valid)
        else $error("byte side stalled without a pending final byte");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_step && s1_last_reg |=> result_valid)
        else $error("final byte produced no result");

    a_result_retires: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !(s1_step && s1_last_reg) |=> !result_valid)
        else $error("result beat repeated");
`endif

endmodule
